// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/grdfs_pkg.sv =====
package grdfs_pkg;
	localparam int MaxVertices = 16;
	localparam int MaxDegree   = 8;
	localparam int LabelWidth  = 16;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_UNREACH     = 3'd1;
	localparam logic [2:0] ST_UNKNOWN     = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
	localparam logic [2:0] ST_DEGREE_FULL = 3'd4;
endpackage

// ===== rtl/graph_reachability_dfs_unit.sv =====
// Undirected graph store with depth-first reachability queries.
// Input item on s_axis: tdata = {dst_label, src_label, operation} from bit 0
// (operation 1 bit, src 16, dst 16, zero padded to 40 bits). Operation 0 adds
// an edge (creating unknown vertices, source first), 1 asks whether dst can
// be reached from src. One result item per input on m_axis: tdata =
// {status, ok} from bit 0, padded to 8 bits.
// Items are handled one at a time. Each label lookup scans the label memory
// entry by entry (read, then compare), followed by a decision step. An add
// then reads both degrees, checks them and writes the source and destination
// slots and degrees. A query clears the visited marks at once, then walks the
// stack in a memory-read loop that expands each unvisited vertex by reading
// its adjacency slots and pops already visited vertices, so its latency grows
// with the graph size.
// Reset empties the graph (vertex count zero) and clears marks and stack
// depth; the memories themselves are not cleared. The result sits in an
// output register until taken; while m_axis_tready is low the block holds it
// and accepts no new item.
`include "assert_macros.svh"
module graph_reachability_dfs_unit #(
	parameter int NUM_VERTICES = grdfs_pkg::MaxVertices,
	parameter int MAX_DEGREE   = grdfs_pkg::MaxDegree,
	parameter int LABEL_WIDTH  = grdfs_pkg::LabelWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// operation, src_label, dst_label
	input  logic [((2*LABEL_WIDTH+8)/8)*8-1:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // ok, status[3]
);
	localparam int VW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
	localparam int CW = $clog2(NUM_VERTICES + 1);
	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int NSLOT = NUM_VERTICES * MAX_DEGREE;
	localparam int SW = $clog2(NSLOT);
	localparam int SCAP = NSLOT + 1;
	localparam int PW = $clog2(SCAP + 1);
	localparam int SIW = $clog2(SCAP);

	localparam logic [3:0] S_IDLE = 4'd0, S_LK_RD = 4'd1, S_LK_CMP = 4'd2,
		S_DECIDE = 4'd3, S_DEG_RD = 4'd4, S_DEG_CHK = 4'd5, S_WR_S = 4'd6,
		S_WR_D = 4'd7, S_POP = 4'd8, S_POP_CHK = 4'd9, S_NB_RD = 4'd10,
		S_NB_CHK = 4'd11, S_OUT = 4'd12, S_DEG_RD2 = 4'd13;

	// memories
	logic [LABEL_WIDTH-1:0] label_mem [NUM_VERTICES];
	logic [DW-1:0]          deg_mem   [NUM_VERTICES];
	logic [VW-1:0]          slot_mem  [NSLOT];
	logic [VW-1:0]          stack_mem [SCAP];

	logic [3:0] state_q;
	logic op_q, which_q, s_ok_q, d_ok_q;
	logic [LABEL_WIDTH-1:0] a_q, b_q;
	logic [VW-1:0] s_idx_q, d_idx_q, v_q;
	logic [CW-1:0] count_q, scan_q;
	logic [DW-1:0] s_deg_q, d_deg_q, nb_i_q;
	logic [NUM_VERTICES-1:0] visited_q;
	logic [PW-1:0] sp_q;
	logic ok_q;
	logic [2:0] status_q;

	// memory read data registers
	logic [LABEL_WIDTH-1:0] label_rd_q;
	logic [DW-1:0] deg_rd_q;
	logic [VW-1:0] slot_rd_q, stack_rd_q;
	logic [VW-1:0] label_ra, deg_ra;
	logic [SW-1:0] slot_ra;
	logic [SIW-1:0] stack_ra;

	logic label_we, deg_we, slot_we, stack_we;
	logic [VW-1:0] label_wa, deg_wa;
	logic [DW-1:0] deg_wd;
	logic [SW-1:0] slot_wa;
	logic [VW-1:0] slot_wd;
	logic [SIW-1:0] stack_wa;
	logic [LABEL_WIDTH-1:0] cur_label;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = {4'd0, status_q, ok_q};
	assign cur_label = which_q ? b_q : a_q;

	function automatic logic [SW-1:0] slot_addr(logic [VW-1:0] v, logic [DW-1:0] i);
		logic [SW+DW-1:0] t;
		t = (SW+DW)'(v) * (SW+DW)'(MAX_DEGREE) + (SW+DW)'(i);
		return t[SW-1:0];
	endfunction

	// read addresses
	always_comb begin
		label_ra = scan_q[VW-1:0];
		deg_ra   = (state_q == S_DEG_RD) ? s_idx_q :
			(state_q == S_DEG_RD2) ? d_idx_q : v_q;
		slot_ra  = slot_addr(v_q, nb_i_q);
		stack_ra = SIW'(sp_q - PW'(1));
	end

	always_ff @(posedge clk) begin
		label_rd_q <= label_mem[label_ra];
		deg_rd_q   <= deg_mem[deg_ra];
		slot_rd_q  <= slot_mem[slot_ra];
		stack_rd_q <= stack_mem[stack_ra];
		if (label_we) label_mem[label_wa] <= cur_label;
		if (deg_we) deg_mem[deg_wa] <= deg_wd;
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		if (stack_we) stack_mem[stack_wa] <= slot_rd_q;
	end

	// write controls
	always_comb begin
		label_we = 1'b0; label_wa = count_q[VW-1:0];
		deg_we = 1'b0; deg_wa = s_idx_q; deg_wd = '0;
		slot_we = 1'b0; slot_wa = slot_addr(s_idx_q, s_deg_q); slot_wd = d_idx_q;
		stack_we = 1'b0; stack_wa = sp_q[SIW-1:0];
		unique case (state_q)
			S_LK_CMP: begin
				if (scan_q == count_q && !(op_q == grdfs_pkg::OP_QUERY)
						&& count_q < CW'(NUM_VERTICES)) begin
					label_we = 1'b1;
					deg_we = 1'b1; deg_wa = count_q[VW-1:0]; deg_wd = '0;
				end
			end
			S_WR_S: begin
				slot_we = 1'b1;
				deg_we = 1'b1; deg_wa = s_idx_q; deg_wd = s_deg_q + DW'(1);
			end
			S_WR_D: begin
				slot_we = 1'b1;
				slot_wa = slot_addr(d_idx_q, (s_idx_q == d_idx_q) ?
					DW'(s_deg_q + DW'(1)) : d_deg_q);
				slot_wd = s_idx_q;
				deg_we = 1'b1; deg_wa = d_idx_q;
				deg_wd = ((s_idx_q == d_idx_q) ? DW'(s_deg_q + DW'(1)) : d_deg_q) + DW'(1);
			end
			S_NB_CHK: begin
				if (slot_rd_q != d_idx_q && !visited_q[slot_rd_q] && sp_q < PW'(SCAP))
					stack_we = 1'b1;
			end
			default: ;
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			visited_q <= '0;
			sp_q <= '0;
			scan_q <= '0;
			which_q <= 1'b0;
			s_ok_q <= 1'b0;
			d_ok_q <= 1'b0;
			op_q <= 1'b0;
			a_q <= '0;
			b_q <= '0;
			s_idx_q <= '0;
			d_idx_q <= '0;
			v_q <= '0;
			s_deg_q <= '0;
			d_deg_q <= '0;
			nb_i_q <= '0;
			ok_q <= 1'b0;
			status_q <= grdfs_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q <= s_axis_tdata[0];
						a_q <= s_axis_tdata[1 +: LABEL_WIDTH];
						b_q <= s_axis_tdata[1 + LABEL_WIDTH +: LABEL_WIDTH];
						which_q <= 1'b0;
						scan_q <= '0;
						s_ok_q <= 1'b0;
						d_ok_q <= 1'b0;
						state_q <= S_LK_RD;
					end
				end
				S_LK_RD: state_q <= S_LK_CMP;
				S_LK_CMP: begin
					if (scan_q != count_q && label_rd_q == cur_label) begin
						if (which_q) begin d_idx_q <= scan_q[VW-1:0]; d_ok_q <= 1'b1; end
						else begin s_idx_q <= scan_q[VW-1:0]; s_ok_q <= 1'b1; end
						state_q <= S_DECIDE;
					end else if (scan_q != count_q) begin
						scan_q <= scan_q + CW'(1);
						state_q <= S_LK_RD;
					end else begin
						// not found: create on add
						if (op_q == grdfs_pkg::OP_ADD && count_q < CW'(NUM_VERTICES)) begin
							if (which_q) begin d_idx_q <= count_q[VW-1:0]; d_ok_q <= 1'b1; end
							else begin s_idx_q <= count_q[VW-1:0]; s_ok_q <= 1'b1; end
							count_q <= count_q + CW'(1);
						end
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!which_q) begin
						which_q <= 1'b1;
						scan_q <= '0;
						state_q <= S_LK_RD;
					end else if (op_q == grdfs_pkg::OP_ADD) begin
						if (!s_ok_q || !d_ok_q) begin
							ok_q <= 1'b0; status_q <= grdfs_pkg::ST_TABLE_FULL;
							state_q <= S_OUT;
						end else state_q <= S_DEG_RD;
					end else begin
						visited_q <= '0;
						sp_q <= '0;
						if (!s_ok_q || !d_ok_q) begin
							ok_q <= 1'b0; status_q <= grdfs_pkg::ST_UNKNOWN;
							state_q <= S_OUT;
						end else if (s_idx_q == d_idx_q) begin
							ok_q <= 1'b1; status_q <= grdfs_pkg::ST_OK;
							state_q <= S_OUT;
						end else begin
							v_q <= s_idx_q;
							state_q <= S_POP_CHK;
						end
					end
				end
				S_DEG_RD: state_q <= S_DEG_RD2;
				S_DEG_RD2: begin
					s_deg_q <= deg_rd_q;
					state_q <= S_DEG_CHK;
				end
				S_DEG_CHK: begin
					d_deg_q <= deg_rd_q;
					if (s_idx_q == d_idx_q ? (32'(s_deg_q) + 2 > MAX_DEGREE)
							: (32'(s_deg_q) >= MAX_DEGREE || 32'(deg_rd_q) >= MAX_DEGREE)) begin
						ok_q <= 1'b0; status_q <= grdfs_pkg::ST_DEGREE_FULL;
						state_q <= S_OUT;
					end else state_q <= S_WR_S;
				end
				S_WR_S: state_q <= S_WR_D;
				S_WR_D: begin
					ok_q <= 1'b1; status_q <= grdfs_pkg::ST_OK;
					state_q <= S_OUT;
				end
				S_POP: begin
					// stack read issued last cycle
					sp_q <= sp_q - PW'(1);
					v_q <= stack_rd_q;
					state_q <= S_POP_CHK;
				end
				S_POP_CHK: begin
					if (visited_q[v_q]) begin
						if (sp_q == '0) begin
							ok_q <= 1'b0; status_q <= grdfs_pkg::ST_UNREACH;
							state_q <= S_OUT;
						end else state_q <= S_POP;
					end else begin
						visited_q[v_q] <= 1'b1;
						nb_i_q <= '0;
						state_q <= S_NB_RD;
					end
				end
				S_NB_RD: begin
					// deg_rd_q holds degree of v_q; slot read issued at nb_i_q
					if (nb_i_q >= deg_rd_q || 32'(nb_i_q) >= MAX_DEGREE) begin
						if (sp_q == '0) begin
							ok_q <= 1'b0; status_q <= grdfs_pkg::ST_UNREACH;
							state_q <= S_OUT;
						end else state_q <= S_POP;
					end else state_q <= S_NB_CHK;
				end
				S_NB_CHK: begin
					if (slot_rd_q == d_idx_q) begin
						ok_q <= 1'b1; status_q <= grdfs_pkg::ST_OK;
						sp_q <= '0;
						state_q <= S_OUT;
					end else begin
						if (stack_we) sp_q <= sp_q + PW'(1);
						nb_i_q <= nb_i_q + DW'(1);
						state_q <= S_NB_RD;
					end
				end
				S_OUT: if (m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_NEVER(a_cnt_max, clk, arst_n, count_q > CW'(NUM_VERTICES), "vertex count overflow")
	`ASSERT_NEVER(a_sp_max, clk, arst_n, sp_q > PW'(SCAP), "stack overflow")
	`ASSERT_CLK(a_out_hold, clk, arst_n,
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)),
		"result changed while stalled")
	`ASSERT_NEVER(a_excl, clk, arst_n, s_axis_tready && m_axis_tvalid, "busy overlap")
endmodule

// ===== dv/graph_reachability_dfs_checker.sv =====
module graph_reachability_dfs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // operation, src_label[16], dst_label[16]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,   // ok, status[3]
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic       ok;
		logic [2:0] status;
	} graph_answer_t;

	// shadow copy of the graph tables
	logic [grdfs_pkg::LabelWidth-1:0] label_tab[grdfs_pkg::MaxVertices];
	int                    n_vertices;
	int                    degree_tab[grdfs_pkg::MaxVertices];
	int                    adj_tab[grdfs_pkg::MaxVertices][grdfs_pkg::MaxDegree];
	graph_answer_t         answer_q[$];

	function automatic int find_vertex(logic [grdfs_pkg::LabelWidth-1:0] lbl);
		for (int i = 0; i < n_vertices; i++)
			if (label_tab[i] == lbl)
				return i;
		return -1;
	endfunction

	function automatic int find_or_add_vertex(logic [grdfs_pkg::LabelWidth-1:0] lbl);
		int v;
		v = find_vertex(lbl);
		if (v < 0 && n_vertices < grdfs_pkg::MaxVertices) begin
			v = n_vertices;
			label_tab[v] = lbl;
			degree_tab[v] = 0;
			n_vertices++;
		end
		return v;
	endfunction

	function automatic graph_answer_t apply_edge(logic [grdfs_pkg::LabelWidth-1:0] a,
			logic [grdfs_pkg::LabelWidth-1:0] b);
		int s;
		int d;
		s = find_or_add_vertex(a);
		d = find_or_add_vertex(b);
		if (s < 0 || d < 0)
			return '{1'b0, grdfs_pkg::ST_TABLE_FULL};
		if (s == d ? degree_tab[s] + 2 > grdfs_pkg::MaxDegree
				: (degree_tab[s] >= grdfs_pkg::MaxDegree
				|| degree_tab[d] >= grdfs_pkg::MaxDegree))
			return '{1'b0, grdfs_pkg::ST_DEGREE_FULL};
		adj_tab[s][degree_tab[s]++] = d;
		adj_tab[d][degree_tab[d]++] = s;
		return '{1'b1, grdfs_pkg::ST_OK};
	endfunction

	function automatic graph_answer_t search_path(logic [grdfs_pkg::LabelWidth-1:0] a,
			logic [grdfs_pkg::LabelWidth-1:0] b);
		int s;
		int d;
		int v;
		int w;
		bit seen[grdfs_pkg::MaxVertices];
		int pile[$];
		s = find_vertex(a);
		d = find_vertex(b);
		if (s < 0 || d < 0)
			return '{1'b0, grdfs_pkg::ST_UNKNOWN};
		if (s == d)
			return '{1'b1, grdfs_pkg::ST_OK};
		pile.push_back(s);
		while (pile.size() > 0) begin
			v = pile.pop_back();
			if (seen[v])
				continue;
			seen[v] = 1'b1;
			for (int i = 0; i < degree_tab[v]; i++) begin
				w = adj_tab[v][i];
				if (w == d)
					return '{1'b1, grdfs_pkg::ST_OK};
				if (!seen[w])
					pile.push_back(w);
			end
		end
		return '{1'b0, grdfs_pkg::ST_UNREACH};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_vertices = 0;
			fail_count <= 0;
			pending <= 0;
			answer_q.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tdata[0] == grdfs_pkg::OP_ADD)
					answer_q.push_back(apply_edge(s_axis_tdata[16:1], s_axis_tdata[32:17]));
				else
					answer_q.push_back(search_path(s_axis_tdata[16:1], s_axis_tdata[32:17]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (answer_q.size() == 0) begin
					$display("%0t: result %h with no item pending", $time, m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					graph_answer_t exp_a;
					exp_a = answer_q.pop_front();
					if (m_axis_tdata[0] !== exp_a.ok || m_axis_tdata[3:1] !== exp_a.status) begin
						$display("%0t: expected ok=%0d status=%0d, got ok=%0d status=%0d",
							$time, exp_a.ok, exp_a.status, m_axis_tdata[0], m_axis_tdata[3:1]);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= answer_q.size();
		end
	end
endmodule

// ===== dv/graph_reachability_dfs_unit_test.sv =====
module graph_reachability_dfs_unit_test;
	localparam int WatchdogLimit = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;    // operation, src_label[16], dst_label[16]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;    // ok, status[3]
	int          fail_count;
	int          pending;
	int          idle_cycles;
	logic [15:0] label_pool[24];

	graph_reachability_dfs_unit dut (.*);
	graph_reachability_dfs_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// drive one item and wait until it is taken; valid stays high after it
	task automatic send_item(logic op, logic [15:0] a, logic [15:0] b);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, b, a, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// random receiver stall
	initial begin
		int g;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			g = gap_len();
			if ($urandom_range(0, 9) < 6 || g == 0)
				m_axis_tready <= 1'b1;
			else begin
				m_axis_tready <= 1'b0;
				repeat (g) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on accepted items
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int used;
		logic op;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		idle_cycles = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unknown query, extremes, self loop, degree and table full
		send_item(grdfs_pkg::OP_QUERY, 16'h0000, 16'hFFFF);
		send_item(grdfs_pkg::OP_ADD, 16'h0000, 16'hFFFF);
		send_item(grdfs_pkg::OP_QUERY, 16'hFFFF, 16'h0000);
		send_item(grdfs_pkg::OP_QUERY, 16'h0000, 16'h0000);
		send_item(grdfs_pkg::OP_QUERY, 16'h0000, 16'h1234);
		send_item(grdfs_pkg::OP_ADD, 16'h5555, 16'h5555);
		send_item(grdfs_pkg::OP_ADD, 16'h5555, 16'h5555);
		send_item(grdfs_pkg::OP_ADD, 16'h5555, 16'h5555);
		send_item(grdfs_pkg::OP_ADD, 16'h5555, 16'h5555);
		send_item(grdfs_pkg::OP_ADD, 16'h5555, 16'h5555);
		send_item(grdfs_pkg::OP_ADD, 16'h5555, 16'hAAAA);
		send_item(grdfs_pkg::OP_QUERY, 16'h0000, 16'h5555);
		for (int i = 0; i < 13; i++)
			send_item(grdfs_pkg::OP_ADD, 16'hAAAA, 16'(16'h0100 + i));
		send_item(grdfs_pkg::OP_ADD, 16'h7777, 16'h8888);

		// the block's graph only grows, so pause then continue with random traffic
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		// random part: pool mostly of vertices already in the table
		for (int i = 0; i < 24; i++)
			label_pool[i] = (i < 12) ? 16'(16'h0100 + i) : 16'($urandom);
		label_pool[12] = 16'h0000;
		label_pool[13] = 16'hFFFF;
		label_pool[14] = 16'h5555;
		label_pool[15] = 16'hAAAA;
		for (int n = 0; n < 1350; n++) begin
			op = ($urandom_range(0, 99) < 65) ? grdfs_pkg::OP_QUERY : grdfs_pkg::OP_ADD;
			used = (n < 300) ? 20 : 24;
			if ($urandom_range(0, 19) == 0)
				send_item(op, 16'($urandom), label_pool[$urandom_range(0, used - 1)]);
			else
				send_item(op, label_pool[$urandom_range(0, used - 1)],
					label_pool[$urandom_range(0, used - 1)]);
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/grdfs_pkg.sv
rtl/graph_reachability_dfs_unit.sv
dv/graph_reachability_dfs_checker.sv
dv/graph_reachability_dfs_unit_test.sv
